// ----- rtl/core/lpe_pkg.sv -----
// Shared constants for the Legendre polynomial evaluator.
package lpe_pkg;

    // Highest degree evaluated; larger requests are clamped to it.
    localparam int MAX_DEGREE = 255;
    // Fraction bits of the fixed-point format.
    localparam int FRAC_BITS  = 30;

    // Port and product widths.
    localparam int DATA_W = 32;
    localparam int DEG_IN_W = 8;
    localparam int PROD_W = 2 * DATA_W;

    // Width of the step index and of the degree after clamping.
    localparam int DEG_W = $clog2(MAX_DEGREE + 1);
    // Width used to compare the incoming degree against the clamp.
    localparam int CMP_W = (DEG_W > DEG_IN_W) ? DEG_W : DEG_IN_W;

    // The recurrence numerator stays below 3 * i * 2^FRAC_BITS.
    localparam int MAG_W    = FRAC_BITS + DEG_W + 3;
    // Quotient bits resolved per divider cycle.
    localparam int DIV_BITS = 8;
    localparam int DIV_CYC  = (MAG_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W    = DIV_CYC * DIV_BITS;
    localparam int DCNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    // Fixed-point one and minus one.
    localparam logic signed [DATA_W-1:0] FX_ONE  = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] FX_MONE = -FX_ONE;

endpackage

// ----- rtl/core/legendre_polynomial_eval.sv -----
// Legendre polynomial evaluator P_n(x) using Bonnet's recurrence on one shared multiplier.
// Degree 0 or 1 gives a registered result in the cycle after the request; a higher degree n
// runs the recurrence steps for degrees 2 to n, each through a product, a rescale, two scaled
// products, a subtract, divider steps of eight quotient bits each, and an update.
// Throughput: one request at a time; busy is high while a request is in work, and the
// receiver cannot stall. Reset (synchronous, active low) idles the sequencer, drops the strobe.
module legendre_polynomial_eval (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [lpe_pkg::DATA_W-1:0]   i_x_value,
    input  logic [lpe_pkg::DEG_IN_W-1:0]        i_degree,
    output logic                                o_valid,
    output logic signed [lpe_pkg::DATA_W-1:0]   o_p_value
);

    localparam int DW = lpe_pkg::DATA_W;
    localparam int PW = lpe_pkg::PROD_W;
    localparam int GW = lpe_pkg::DEG_W;
    localparam int VW = lpe_pkg::DIV_W;

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RES  = 3'd2;
    localparam logic [2:0] S_MA   = 3'd3;
    localparam logic [2:0] S_MB   = 3'd4;
    localparam logic [2:0] S_SUB  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_UPD  = 3'd7;

    localparam logic [VW-1:0] Q_ONE = VW'(1) << lpe_pkg::FRAC_BITS;
    localparam logic signed [PW-1:0] RND_MASK = (PW'(1) << lpe_pkg::FRAC_BITS) - PW'(1);

    logic [2:0]                    r_state;
    logic                          r_valid;
    logic signed [DW-1:0]          r_p_out;
    logic signed [DW-1:0]          r_x;
    logic signed [DW-1:0]          r_p1;
    logic signed [DW-1:0]          r_p2;
    logic signed [DW-1:0]          r_t;
    logic signed [PW-1:0]          r_prod;
    logic signed [PW-1:0]          r_a;
    logic [GW-1:0]                 r_i;
    logic [GW-1:0]                 r_n;
    logic                          r_neg;
    logic [VW-1:0]                 r_mag;
    logic [GW-1:0]                 r_rem;
    logic [lpe_pkg::DCNT_W-1:0]    r_dcnt;

    logic signed [DW-1:0]          x_sat;
    logic [lpe_pkg::CMP_W-1:0]     deg_ext;
    logic [lpe_pkg::CMP_W-1:0]     max_ext;
    logic [GW-1:0]                 deg_sat;
    logic [GW:0]                   c_odd;
    logic [GW-1:0]                 c_prev;
    logic signed [DW-1:0]          mul_a;
    logic signed [DW-1:0]          mul_b;
    logic signed [PW-1:0]          mul_p;
    logic signed [PW-1:0]          scaled;
    logic signed [PW-1:0]          diff;
    logic [PW-1:0]                 diff_abs;
    logic [GW-1:0]                 n_rem;
    logic [VW-1:0]                 n_mag;
    logic                          n_valid;
    logic [VW-1:0]                 q_sat;
    logic signed [DW-1:0]          q_mag;
    logic signed [DW-1:0]          step_res;
    logic                          accept;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_p_value = r_p_out;

    // Clamp the argument to [-1, 1] and the degree to the supported maximum.
    assign x_sat   = (i_x_value > lpe_pkg::FX_ONE)  ? lpe_pkg::FX_ONE :
                     (i_x_value < lpe_pkg::FX_MONE) ? lpe_pkg::FX_MONE : i_x_value;
    assign deg_ext = lpe_pkg::CMP_W'(i_degree);
    assign max_ext = lpe_pkg::CMP_W'(lpe_pkg::MAX_DEGREE);
    assign deg_sat = (deg_ext > max_ext) ? max_ext[GW-1:0] : deg_ext[GW-1:0];

    // Recurrence coefficients 2i-1 and i-1.
    assign c_odd  = {r_i, 1'b0} - (GW+1)'(1);
    assign c_prev = r_i - GW'(1);

    // Shared multiplier with its operands chosen by the sequencer state.
    always_comb begin
        case (r_state)
            S_MA: begin
                mul_a = r_t;
                mul_b = DW'(c_odd);
            end
            S_MB: begin
                mul_a = r_p2;
                mul_b = DW'(c_prev);
            end
            default: begin
                mul_a = r_x;
                mul_b = r_p1;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Drop the fraction bits, truncating toward zero.
    assign scaled = (r_prod + (r_prod[PW-1] ? RND_MASK : '0)) >>> lpe_pkg::FRAC_BITS;

    // Numerator of the step, split into sign and magnitude for the divider.
    assign diff     = r_a - r_prod;
    assign diff_abs = diff[PW-1] ? PW'(-diff) : PW'(diff);

    // Restoring division of the magnitude by the step index, eight bits per cycle.
    always_comb begin
        logic [GW:0] ext;
        n_rem = r_rem;
        n_mag = r_mag;
        for (int k = 0; k < lpe_pkg::DIV_BITS; k++) begin
            ext   = {n_rem, n_mag[VW-1]};
            n_mag = {n_mag[VW-2:0], 1'b0};
            if (ext >= {1'b0, r_i}) begin
                n_rem    = GW'(ext - {1'b0, r_i});
                n_mag[0] = 1'b1;
            end else begin
                n_rem = ext[GW-1:0];
            end
        end
    end

    // Saturate the quotient to one and restore the sign.
    assign q_sat    = (r_mag > Q_ONE) ? Q_ONE : r_mag;
    assign q_mag    = DW'(q_sat[lpe_pkg::FRAC_BITS:0]);
    assign step_res = r_neg ? -q_mag : q_mag;

    // The strobe is registered from the accept of a short request, or from the last recurrence step.
    assign n_valid = (accept && (deg_sat < GW'(2))) ||
                     ((r_state == S_UPD) && (r_i == r_n));

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (deg_sat == GW'(0)) begin
                            r_p_out <= lpe_pkg::FX_ONE;
                        end else if (deg_sat == GW'(1)) begin
                            r_p_out <= x_sat;
                        end else begin
                            r_x     <= x_sat;
                            r_p1    <= x_sat;
                            r_p2    <= lpe_pkg::FX_ONE;
                            r_i     <= GW'(2);
                            r_n     <= deg_sat;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_RES;
                end
                S_RES: begin
                    r_t     <= scaled[DW-1:0];
                    r_state <= S_MA;
                end
                S_MA: begin
                    r_a     <= mul_p;
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_prod  <= mul_p;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_neg   <= diff[PW-1];
                    r_mag   <= diff_abs[VW-1:0];
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_mag  <= n_mag;
                    r_rem  <= n_rem;
                    r_dcnt <= r_dcnt + lpe_pkg::DCNT_W'(1);
                    if (r_dcnt == lpe_pkg::DCNT_W'(lpe_pkg::DIV_CYC - 1)) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_p2 <= r_p1;
                    r_p1 <= step_res;
                    if (r_i == r_n) begin
                        r_p_out <= step_res;
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + GW'(1);
                        r_state <= S_MUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A finished request always ends with a result strobe.
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_valid)
        else $error("busy dropped without a result");

    // Results stay within [-1, 1].
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_p_value <= lpe_pkg::FX_ONE && o_p_value >= lpe_pkg::FX_MONE))
        else $error("result outside unit range");

    // A request of degree two or more starts the recurrence.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_degree >= lpe_pkg::DEG_IN_W'(2)) |=> (busy && !o_valid))
        else $error("recurrence did not start");

    // The divider remainder stays below the divisor.
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_i))
        else $error("divider remainder out of range");

endmodule
